[design/battery_status_fault_qualifier_unit_macros.svh]
// Assertion macros shared by the battery status fault qualifier RTL.
`ifndef BATTERY_STATUS_FAULT_QUALIFIER_UNIT_MACROS_SVH
`define BATTERY_STATUS_FAULT_QUALIFIER_UNIT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define BSFQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define BSFQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/bsfq_pkg.sv]
// Shared types and constants for the battery status fault qualifier.
package bsfq_pkg;

    // Charger state codes
    localparam logic [2:0] CHG_UNKNOWN      = 3'd0;
    localparam logic [2:0] CHG_NOT_CHARGING = 3'd1;
    localparam logic [2:0] CHG_CHARGING     = 3'd2;
    localparam logic [2:0] CHG_CHARGED      = 3'd3;
    localparam logic [2:0] CHG_DISCHARGING  = 3'd4;
    localparam logic [2:0] CHG_FAULT        = 3'd5;
    localparam logic [2:0] CHG_DISCONNECTED = 3'd6;

    // Alert codes, one per fault lane
    localparam logic [1:0] ALERT_UNKNOWN      = 2'd0;
    localparam logic [1:0] ALERT_NOT_CHARGING = 2'd1;
    localparam logic [1:0] ALERT_FAULT        = 2'd2;
    localparam logic [1:0] ALERT_DISCONNECTED = 2'd3;

    localparam int NUM_FAULTS = 4;

    // Configuration registers
    localparam int          APB_ADDR_W      = 3;
    localparam int          APB_DATA_W      = 32;
    localparam int          LIMIT_W         = 8;
    localparam logic [2:0]  REG_LIMIT_ADDR  = 3'd0;
    localparam logic [7:0]  LIMIT_RESET     = 8'd10;

    localparam int TALLY_BITS_DEF = 8;

    // One result word
    typedef struct packed {
        logic       led_charged;
        logic       led_charging;
        logic       led_fault;
        logic       alert_valid;
        logic [1:0] alert_code;
    } t_result;

endpackage

[design/bsfq_if.sv]
// Valid/ready channel interfaces for poll ticks and status results.
interface bsfq_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] charger_state;
    logic       running_on_battery;

    modport source (output valid, output charger_state, output running_on_battery,
                    input ready);
    modport sink   (input valid, input charger_state, input running_on_battery,
                    output ready);
endinterface

interface bsfq_out_if;
    logic       valid;
    logic       ready;
    logic       led_charged;
    logic       led_charging;
    logic       led_fault;
    logic       alert_valid;
    logic [1:0] alert_code;

    modport source (output valid, output led_charged, output led_charging,
                    output led_fault, output alert_valid, output alert_code,
                    input ready);
    modport sink   (input valid, input led_charged, input led_charging,
                    input led_fault, input alert_valid, input alert_code,
                    output ready);
endinterface

[design/bsfq_regs.sv]
// APB configuration register file: fault persistence limit.
module bsfq_regs
    import bsfq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [LIMIT_W-1:0]    o_limit
);

    logic [LIMIT_W-1:0] r_limit;
    logic               wr_limit;

    assign pready   = 1'b1;
    assign wr_limit = psel && penable && pwrite && (paddr == REG_LIMIT_ADDR);

    // Limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (wr_limit) begin
            r_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    // Readback
    always_comb begin
        prdata = '0;
        if (paddr == REG_LIMIT_ADDR) begin
            prdata = APB_DATA_W'(r_limit);
        end
    end

    assign o_limit = r_limit;

endmodule

[design/bsfq_core.sv]
// Status flags, fault tallies and LED levels, updated once per poll tick.
module bsfq_core
    import bsfq_pkg::*;
#(
    parameter int TALLY_BITS = TALLY_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [2:0]         i_charger_state,
    input  logic               i_on_battery,
    input  logic [LIMIT_W-1:0] i_limit,
    output t_result            o_result
);
`include "battery_status_fault_qualifier_unit_macros.svh"

    localparam int CMP_W = (TALLY_BITS > LIMIT_W) ? TALLY_BITS : LIMIT_W;

    logic                  r_charged_seen, n_charged_seen;
    logic                  r_charging_phase, n_charging_phase;
    logic                  r_battery_seen, n_battery_seen;
    logic                  r_clear_done, n_clear_done;
    logic                  r_led_chg_done, n_led_chg_done;
    logic                  r_led_chg_on, n_led_chg_on;
    logic                  r_led_flt, n_led_flt;
    logic [NUM_FAULTS-1:0] r_latched, n_latched;
    logic [TALLY_BITS-1:0] r_tally [NUM_FAULTS];
    logic [TALLY_BITS-1:0] n_tally [NUM_FAULTS];

    logic [NUM_FAULTS-1:0] fault_hit;
    logic                  alert;
    logic [1:0]            code;

    // Which fault lane this state feeds; other codes are the clearing case
    always_comb begin
        fault_hit = '0;
        unique case (i_charger_state)
            CHG_UNKNOWN:      fault_hit[ALERT_UNKNOWN]      = 1'b1;
            CHG_NOT_CHARGING: fault_hit[ALERT_NOT_CHARGING] = 1'b1;
            CHG_FAULT:        fault_hit[ALERT_FAULT]        = 1'b1;
            CHG_DISCONNECTED: fault_hit[ALERT_DISCONNECTED] = 1'b1;
            default:          fault_hit = '0;
        endcase
    end

    // Next state for one tick
    always_comb begin
        n_charged_seen   = r_charged_seen;
        n_charging_phase = r_charging_phase;
        n_battery_seen   = r_battery_seen;
        n_clear_done     = r_clear_done;
        n_led_chg_done   = r_led_chg_done;
        n_led_chg_on     = r_led_chg_on;
        n_led_flt        = r_led_flt;
        n_latched        = r_latched;
        alert            = 1'b0;
        code             = ALERT_UNKNOWN;
        for (int k = 0; k < NUM_FAULTS; k++) begin
            n_tally[k] = r_tally[k];
        end

        // Newly charged
        if (i_charger_state == CHG_CHARGED && !n_charged_seen) begin
            n_charged_seen   = 1'b1;
            n_charging_phase = 1'b0;
            n_battery_seen   = 1'b0;
            n_led_flt        = 1'b0;
            n_led_chg_on     = 1'b0;
            n_led_chg_done   = 1'b1;
        end

        // Charging: blink on alternate ticks
        if (i_charger_state == CHG_CHARGING) begin
            n_led_flt      = 1'b0;
            n_led_chg_done = 1'b0;
            if (!n_charging_phase) begin
                n_charged_seen   = 1'b0;
                n_battery_seen   = 1'b0;
                n_charging_phase = 1'b1;
                n_led_chg_on     = 1'b0;
            end else begin
                n_charging_phase = 1'b0;
                n_led_chg_on     = 1'b1;
            end
        end

        // Switched onto battery
        if (i_on_battery && !n_battery_seen) begin
            n_battery_seen   = 1'b1;
            n_charged_seen   = 1'b0;
            n_charging_phase = 1'b0;
            n_led_chg_done   = 1'b0;
            n_led_chg_on     = 1'b0;
        end

        // Fault lanes: saturating tally, one-shot alert past the limit
        if (|fault_hit) begin
            for (int k = 0; k < NUM_FAULTS; k++) begin
                if (fault_hit[k]) begin
                    if (r_tally[k] != '1) begin
                        n_tally[k] = r_tally[k] + 1'b1;
                    end
                    if (CMP_W'(n_tally[k]) > CMP_W'(i_limit) && !r_latched[k]) begin
                        n_tally[k]   = '0;
                        n_latched[k] = 1'b1;
                        alert        = 1'b1;
                        code         = 2'(k);
                    end
                end
            end
            if (alert) begin
                n_clear_done     = 1'b0;
                n_charged_seen   = 1'b0;
                n_charging_phase = 1'b0;
                n_led_chg_done   = 1'b0;
                n_led_chg_on     = 1'b0;
                n_led_flt        = 1'b1;
            end
        end else if (!r_clear_done) begin
            n_clear_done = 1'b1;
            n_latched    = '0;
            n_led_flt    = 1'b0;
            for (int k = 0; k < NUM_FAULTS; k++) begin
                n_tally[k] = '0;
            end
        end
    end

    // State registers, advanced on each processed tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charged_seen   <= 1'b0;
            r_charging_phase <= 1'b0;
            r_battery_seen   <= 1'b0;
            r_clear_done     <= 1'b0;
            r_led_chg_done   <= 1'b0;
            r_led_chg_on     <= 1'b0;
            r_led_flt        <= 1'b0;
            r_latched        <= '0;
            for (int k = 0; k < NUM_FAULTS; k++) begin
                r_tally[k] <= '0;
            end
        end else if (i_step) begin
            r_charged_seen   <= n_charged_seen;
            r_charging_phase <= n_charging_phase;
            r_battery_seen   <= n_battery_seen;
            r_clear_done     <= n_clear_done;
            r_led_chg_done   <= n_led_chg_done;
            r_led_chg_on     <= n_led_chg_on;
            r_led_flt        <= n_led_flt;
            r_latched        <= n_latched;
            for (int k = 0; k < NUM_FAULTS; k++) begin
                r_tally[k] <= n_tally[k];
            end
        end
    end

    assign o_result.led_charged  = n_led_chg_done;
    assign o_result.led_charging = n_led_chg_on;
    assign o_result.led_fault    = n_led_flt;
    assign o_result.alert_valid  = alert;
    assign o_result.alert_code   = code;

    // Checks
    `BSFQ_ASSERT(a_alert_lights_fault, i_clk, i_rst_n, (i_step && alert) |=> r_led_flt, "alert without fault LED")
    `BSFQ_ASSERT(a_alert_rearms_clear, i_clk, i_rst_n, (i_step && alert) |=> !r_clear_done, "alert left clear_done set")
    `BSFQ_ASSERT(a_charge_leds_excl, i_clk, i_rst_n, !(r_led_chg_done && r_led_chg_on), "charged and charging LEDs both on")

endmodule

[design/battery_status_fault_qualifier_unit.sv]
// An accepted tick is held in the input register, then moved into the output register.
// One tick per cycle unless the output register is full and not taken.
// The tick's whole update is one pass of flag and tally logic between the two registers.
// Reset (i_rst_n low at a clock edge) clears flags, tallies, LEDs and both registers' valids,
// and sets the fault persistence limit back to 10.
module battery_status_fault_qualifier_unit
    import bsfq_pkg::*;
#(
    parameter int TALLY_BITS = TALLY_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bsfq_in_if.sink               i_in,
    bsfq_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
`include "battery_status_fault_qualifier_unit_macros.svh"

    logic               r_in_valid;
    logic [2:0]         r_in_state;
    logic               r_in_on_bat;
    logic               r_out_valid;
    t_result            r_out;
    t_result            step_result;
    logic [LIMIT_W-1:0] limit;
    logic               advance;
    logic               in_ready;

    // Tick moves from input register to output register
    assign advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_ready = !r_in_valid || advance;
    assign i_in.ready = in_ready;

    bsfq_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_limit (limit)
    );

    bsfq_core #(
        .TALLY_BITS (TALLY_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (advance),
        .i_charger_state (r_in_state),
        .i_on_battery    (r_in_on_bat),
        .i_limit         (limit),
        .o_result        (step_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in_state  <= i_in.charger_state;
            r_in_on_bat <= i_in.running_on_battery;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.led_charged  = r_out.led_charged;
    assign o_out.led_charging = r_out.led_charging;
    assign o_out.led_fault    = r_out.led_fault;
    assign o_out.alert_valid  = r_out.alert_valid;
    assign o_out.alert_code   = r_out.alert_code;

    // Checks
    `BSFQ_ASSERT(a_ready_when_out_empty, i_clk, i_rst_n, !r_out_valid |-> in_ready, "input stalled with empty output register")
    `BSFQ_ASSERT(a_advance_fills_out, i_clk, i_rst_n, advance |=> r_out_valid, "processed word not presented")
    `BSFQ_ASSERT(a_charged_fault_excl, i_clk, i_rst_n, r_out_valid |-> !(r_out.led_charged && r_out.led_fault), "charged and fault LEDs both on")

endmodule
